### sv/cde_pkg.sv
package cde_pkg;

  localparam int unsigned MAX_CELLS  = 65536;
  localparam int unsigned HASH_SLOTS = 131072;
  localparam int unsigned KEY_HALF   = 32;
  localparam int unsigned SLOT_W     = $clog2(HASH_SLOTS);
  localparam int unsigned EPOCH_W    = 8;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned TOT_W      = 17;

  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
  localparam logic [SLOT_W-1:0]  SLOT_LAST   = SLOT_W'(HASH_SLOTS - 1);

  typedef struct packed {
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] expr_count;
    logic        first_of_set;
    logic        last_of_set;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             is_new;
    logic [31:0]      count_out;
    logic             overflow;
    logic [TOT_W-1:0] unique_total;
    logic             set_done;
  } rsp_t;

  // one table slot; a slot is live only when its epoch matches the current one
  typedef struct packed {
    logic [2*KEY_HALF-1:0] key;
    logic [IDX_W-1:0]      id;
    logic [EPOCH_W-1:0]    epoch;
  } slot_t;

  localparam int unsigned SLOT_BITS = $bits(slot_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_e;

  function automatic logic [SLOT_W-1:0] hash_slot(input logic [2*KEY_HALF-1:0] key);
    logic [31:0] h;
    h = key[31:0] ^ {1'b0, key[63:33]} ^ {key[20:0], 11'b0};
    return h[SLOT_W-1:0];
  endfunction

endpackage

### sv/cde_table_ram.sv
module cde_table_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/cde_probe_ctrl.sv
module cde_probe_ctrl import cde_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_take_i,
  output rsp_t              rsp_o,
  output logic              wr_en_o,
  output logic [SLOT_W-1:0] wr_addr_o,
  output slot_t             wr_data_o,
  output logic              rd_en_o,
  output logic [SLOT_W-1:0] rd_addr_o,
  input  slot_t             rd_data_i
);

  state_e              state_q, state_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [TOT_W-1:0]    distinct_q, distinct_d;
  logic [SLOT_W-1:0]   pos_q, pos_d;
  logic [SLOT_W-1:0]   probes_q, probes_d;
  logic [SLOT_W-1:0]   clr_q, clr_d;
  logic                pend_q, pend_d;
  req_t                req_q, req_d;
  rsp_t                rsp_q, rsp_d;

  logic [2*KEY_HALF-1:0] key;
  logic                  live, hit, room;
  logic [SLOT_W-1:0]     pos_next;

  assign key      = {req_q.coord_x, req_q.coord_y};
  assign live     = (rd_data_i.epoch == epoch_q);
  assign hit      = live && (rd_data_i.key == key);
  assign room     = (32'(distinct_q) < 32'(MAX_CELLS));
  assign pos_next = (pos_q == SLOT_LAST) ? '0 : pos_q + SLOT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == SLOT_LAST) state_d = pend_q ? ST_PROBE : ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = (req_i.first_of_set && epoch_q == EPOCH_LAST) ? ST_CLEAR : ST_PROBE;
        end
      end
      ST_PROBE: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!live || hit || probes_q == SLOT_LAST) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_take_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    epoch_d    = epoch_q;
    distinct_d = distinct_q;
    pos_d      = pos_q;
    probes_d   = probes_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    req_d      = req_q;
    rsp_d      = rsp_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = pos_q;
    wr_data_o  = '{key: key, id: distinct_q[IDX_W-1:0], epoch: epoch_q};
    rd_en_o    = 1'b0;
    rd_addr_o  = pos_q;
    case (state_q)
      ST_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = '{key: '0, id: '0, epoch: EPOCH_NONE};
        clr_d     = clr_q + SLOT_W'(1);
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          req_d  = req_i;
          pend_d = 1'b1;
          if (req_i.first_of_set) begin
            distinct_d = '0;
            epoch_d    = (epoch_q == EPOCH_LAST) ? EPOCH_FIRST : epoch_q + EPOCH_W'(1);
          end
        end
      end
      ST_PROBE: begin
        rd_en_o   = 1'b1;
        rd_addr_o = hash_slot(key);
        pos_d     = hash_slot(key);
        probes_d  = '0;
      end
      ST_CHECK: begin
        rsp_d.count_out = req_q.expr_count;
        rsp_d.set_done  = req_q.last_of_set;
        rsp_d.is_new    = 1'b0;
        rsp_d.overflow  = 1'b0;
        rsp_d.cell_index = '0;
        rsp_d.unique_total = distinct_q;
        if (hit) begin
          rsp_d.cell_index = rd_data_i.id;
        end else if (!live && room) begin
          wr_en_o            = 1'b1;
          rsp_d.cell_index   = distinct_q[IDX_W-1:0];
          rsp_d.is_new       = 1'b1;
          distinct_d         = distinct_q + TOT_W'(1);
          rsp_d.unique_total = distinct_q + TOT_W'(1);
        end else if (!live || probes_q == SLOT_LAST) begin
          rsp_d.overflow = 1'b1;
        end else begin
          // keep walking: read the following slot right away
          rd_en_o   = 1'b1;
          rd_addr_o = pos_next;
          pos_d     = pos_next;
          probes_d  = probes_q + SLOT_W'(1);
        end
      end
      ST_DONE: begin
        if (rsp_take_i) pend_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      epoch_q    <= EPOCH_FIRST;
      distinct_q <= '0;
      clr_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      epoch_q    <= epoch_d;
      distinct_q <= distinct_d;
      clr_q      <= clr_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    probes_q <= probes_d;
    req_q    <= req_d;
    rsp_q    <= rsp_d;
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_DONE);
  assign rsp_o       = rsp_q;

endmodule

### sv/coordinate_dictionary_encoder.sv
// Assigns dense indices to (x, y) coordinates in first-seen order via a
// linear-probing hash table held in one single-port-write, registered-read RAM.
// A request probes slots one per cycle through the RAM read port. Slots are
// tagged with a set epoch, so first_of_set costs nothing, except that after
// reset and on every 255th set start the table is swept once, writing every
// slot, with no request taken meanwhile. The result sits in an output
// register, so the next request may be accepted while a result waits.
module coordinate_dictionary_encoder import cde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  logic              ready, rsp_valid, rsp_take;
  rsp_t              rsp;
  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  slot_t             wr_data, rd_data;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q;

  cde_probe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (ready),
    .req_i       (in_data_i),
    .rsp_valid_o (rsp_valid),
    .rsp_take_i  (rsp_take),
    .rsp_o       (rsp),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data)
  );

  cde_table_ram #(
    .DATA_W (SLOT_BITS),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = !ready;
  assign rsp_take   = rsp_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_take) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_take) out_q <= rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/cde_checker.sv
module cde_checker import cde_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is in flight");

  a_new_xor_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.is_new && out_data_o.overflow))
    else $error("result both new and overflow");

  a_ovf_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.cell_index == '0)
    else $error("overflow with nonzero index");

endmodule

bind coordinate_dictionary_encoder cde_checker u_cde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
